// File: hdl/sbvs_pkg.sv
// ----------------------------------------------------------------------------
// sbvs_pkg: shared definitions for the sparse brick voxel store
// Geometry constants, register map, default parameter values and the
// controller state type.
// ----------------------------------------------------------------------------
package sbvs_pkg;

  // Coordinate and geometry (bricks 8 voxels on a side, on a grid 16 cells on a side)
  localparam int COORD_W   = 7;
  localparam int BRICK_W   = 3;                  // log2 of brick side
  localparam int GRID_W    = 4;                  // log2 of grid side
  localparam int CELL_W    = 3 * GRID_W;         // cell table address
  localparam int LOCAL_W   = 3 * BRICK_W;        // voxel offset inside a brick
  localparam int SUPER_BIT = 3;                  // cell coord bit that picks the supercell
  localparam int SLICE_W   = 16;
  localparam int SUPER_W   = 8;

  // Default parameter values
  localparam int SLOT_COUNT_DEF = 256;
  localparam int VOXEL_BITS_DEF = 32;

  // Register map
  localparam int            ADDR_W          = 2;
  localparam logic [ADDR_W-1:0] REG_SLOT_LIMIT = 2'd0;
  localparam int            LIMIT_W         = 9;
  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 9'd256;

  // Item modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_OUT
  } state_t;

endpackage

// File: hdl/sparse_brick_voxel_store.sv
// ----------------------------------------------------------------------------
// sparse_brick_voxel_store: two-level sparse voxel map
// Result strobe (done) is raised in ST_OUT, the state after the ST_LOOK state
//   that follows an accepted start. A new start may be taken in ST_OUT; the
//   cell table read must land before the dependent voxel memory access.
// Reset: a clearing pass over max(SLOT_COUNT*512, 4096) entries zeroes the voxel
//   memory and cell table; busy stays high until it ends. Results cannot stall.
// ----------------------------------------------------------------------------
module sparse_brick_voxel_store #(
  parameter int SLOT_COUNT = sbvs_pkg::SLOT_COUNT_DEF,
  parameter int VOXEL_BITS = sbvs_pkg::VOXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbvs_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [sbvs_pkg::COORD_W-1:0]        pos_x,
  input  logic [sbvs_pkg::COORD_W-1:0]        pos_y,
  input  logic [sbvs_pkg::COORD_W-1:0]        pos_z,
  input  logic [31:0]                         voxel_value,
  // result
  output logic                                done,
  output logic [31:0]                         read_value,
  output logic                                dropped,
  output logic                                allocated,
  output logic [7:0]                          slot_index,
  output logic [sbvs_pkg::SUPER_W-1:0]        super_map,
  output logic [sbvs_pkg::SLICE_W-1:0]        slice_map
);
  import sbvs_pkg::*;

  localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int VOX_DEPTH = SLOT_COUNT * (1 << LOCAL_W);
  localparam int VOX_AW    = SLOT_W + LOCAL_W;
  localparam int CELLS     = 1 << CELL_W;
  localparam int CLR_DEPTH = (VOX_DEPTH > CELLS) ? VOX_DEPTH : CELLS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  // Memories: cell entry is {valid, slot}
  logic [SLOT_W:0]         cell_mem [CELLS];
  logic [VOXEL_BITS-1:0]   vox_mem  [VOX_DEPTH];

  state_t state, state_next;
  logic [CLR_W-1:0]        clr_cnt;
  logic [LIMIT_W-1:0]      slot_limit;
  logic [LIMIT_W-1:0]      next_slot;
  logic [SUPER_W-1:0]      super_bits;
  logic [SLICE_W-1:0]      slice_bits;

  // Captured item
  logic                    item_mode;
  logic [CELL_W-1:0]       item_cell;
  logic [LOCAL_W-1:0]      item_local;
  logic [31:0]             item_value;

  // Memory read data and result registers
  logic [SLOT_W:0]         cell_rd;
  logic [VOXEL_BITS-1:0]   vox_rd;
  logic                    rd_hit;
  logic                    res_dropped;
  logic                    res_alloc;
  logic [7:0]              res_slot;

  logic                    accept;
  logic                    clearing;
  logic                    look;
  logic                    cell_hit;
  logic [SLOT_W-1:0]       cell_slot;
  logic                    pool_full;
  logic                    do_alloc;
  logic                    do_drop;
  logic                    owns;
  logic [SLOT_W-1:0]       eff_slot;
  logic [31:0]             eff_slot_ext;
  logic [CELL_W-1:0]       in_cell;
  logic [2:0]              super_idx;
  logic [GRID_W-1:0]       cell_by;
  logic                    cell_we;
  logic [CELL_W-1:0]       cell_waddr;
  logic [SLOT_W:0]         cell_wdata;
  logic                    vox_we;
  logic                    vox_re;
  logic [VOX_AW-1:0]       vox_addr;
  logic [VOXEL_BITS-1:0]   vox_wdata;
  logic                    cfg_write;

  // Config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_SLOT_LIMIT) ? 32'(slot_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= SLOT_LIMIT_RESET;
    end else if (cfg_write && paddr == REG_SLOT_LIMIT) begin
      slot_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_OUT;
      ST_OUT:   state_next = start ? ST_LOOK : ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    clearing = 1'b0;
    look     = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_LOOK:  look = 1'b1;
      ST_OUT: begin
        busy = 1'b0;
        done = 1'b1;
      end
      default:  busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Cell address of the incoming item: cell coords are the high coord bits
  assign in_cell = {pos_z[COORD_W-1:BRICK_W], pos_y[COORD_W-1:BRICK_W],
                    pos_x[COORD_W-1:BRICK_W]};

  // Capture item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= mode;
      item_cell  <= in_cell;
      item_local <= {pos_z[BRICK_W-1:0], pos_y[BRICK_W-1:0], pos_x[BRICK_W-1:0]};
      item_value <= voxel_value;
    end
  end

  // Lookup decision, in the cycle after the cell table read
  assign cell_hit     = cell_rd[SLOT_W];
  assign cell_slot    = cell_rd[SLOT_W-1:0];
  assign pool_full    = (next_slot >= slot_limit) || (32'(next_slot) >= 32'(SLOT_COUNT));
  assign do_alloc     = (item_mode == MODE_WRITE) && !cell_hit && !pool_full;
  assign do_drop      = (item_mode == MODE_WRITE) && !cell_hit && pool_full;
  assign owns         = cell_hit || do_alloc;
  assign eff_slot     = cell_hit ? cell_slot : SLOT_W'(next_slot);
  assign eff_slot_ext = 32'(eff_slot);
  assign cell_by      = item_cell[2*GRID_W-1:GRID_W];
  assign super_idx    = {item_cell[2*GRID_W+SUPER_BIT], item_cell[GRID_W+SUPER_BIT],
                         item_cell[SUPER_BIT]};

  // Memory port control: clearing pass or lookup stage
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = item_cell;
    cell_wdata = {1'b1, eff_slot};
    vox_we     = 1'b0;
    vox_re     = 1'b0;
    vox_addr   = {eff_slot, item_local};
    vox_wdata  = VOXEL_BITS'(item_value);
    if (clearing) begin
      cell_we    = 1'b1;
      cell_waddr = clr_cnt[CELL_W-1:0];
      cell_wdata = '0;
      vox_we     = 32'(clr_cnt) < 32'(VOX_DEPTH);
      vox_addr   = clr_cnt[VOX_AW-1:0];
      vox_wdata  = '0;
    end else if (look) begin
      cell_we = do_alloc;
      vox_we  = (item_mode == MODE_WRITE) && owns;
      vox_re  = (item_mode == MODE_READ) && cell_hit;
    end
  end

  // Cell table
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (accept)  cell_rd <= cell_mem[in_cell];
  end

  // Voxel memory
  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_addr] <= vox_wdata;
    if (vox_re) vox_rd <= vox_mem[vox_addr];
  end

  // Allocator and occupancy maps
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot  <= LIMIT_W'(1);
      super_bits <= '0;
      slice_bits <= '0;
    end else if (look && do_alloc) begin
      next_slot  <= next_slot + 1'b1;
      super_bits <= super_bits | (SUPER_W'(1) << super_idx);
      slice_bits <= slice_bits | (SLICE_W'(1) << cell_by);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (look) begin
      rd_hit      <= (item_mode == MODE_READ) && cell_hit;
      res_dropped <= do_drop;
      res_alloc   <= do_alloc;
      res_slot    <= owns ? eff_slot_ext[7:0] : '0;
    end
  end

  assign read_value = rd_hit ? 32'(vox_rd) : '0;
  assign dropped    = res_dropped;
  assign allocated  = res_alloc;
  assign slot_index = res_slot;
  assign super_map  = super_bits;
  assign slice_map  = slice_bits;

endmodule
